// ===== hdl/tile_order_space_enumerator_assert.svh =====
// Assertion macros for the tile order space enumerator checker.
// Both macros expect clk to be visible where they are used; TOSE_ASSERT also expects rst_n.
`ifndef TILE_ORDER_SPACE_ENUMERATOR_ASSERT_SVH
`define TILE_ORDER_SPACE_ENUMERATOR_ASSERT_SVH

// Property checked outside reset.
`define TOSE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Property checked at every edge, reset included.
`define TOSE_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ===== hdl/tose_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tose_pkg;

    localparam int MAX_DIMS    = 4;
    localparam int EXTENT_BITS = 12;
    localparam int SIZE_W      = EXTENT_BITS + 1;
    localparam int NODE_W      = 16;
    localparam int COUNT_W     = 3;
    localparam int DIM_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] REG_NODE_ID   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT_0  = 3'd2;

    localparam logic [STATUS_W-1:0] ST_OK            = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_IN_DOMAIN = 2'd2;

    typedef logic [SIZE_W-1:0]   size_t;
    typedef logic [COUNT_W-1:0]  count_t;
    typedef logic [DIM_W-1:0]    dim_t;
    typedef logic [STATUS_W-1:0] status_t;

    typedef struct packed {
        logic [NODE_W-1:0]         node_id;
        count_t                    dim_count;
        size_t [MAX_DIMS-1:0]      extent;
    } cfg_t;

    typedef struct packed {
        logic [NODE_W-1:0]         node;
        count_t                    size_count;
        size_t [MAX_DIMS-1:0]      size;
        count_t                    order_count;
        dim_t [MAX_DIMS-1:0]       order;
    } item_t;

    // After the per-dimension range checks.
    typedef struct packed {
        logic                      pre_ok;
        logic [MAX_DIMS-1:0]       active;
        size_t [MAX_DIMS-1:0]      size;
        count_t                    order_count;
        dim_t [MAX_DIMS-1:0]       order;
    } s1_t;

    // After the order check and the search for pivot, swap and decrement points.
    typedef struct packed {
        logic                      ok;
        logic                      perm;
        logic                      found;
        dim_t                      pivot;
        dim_t                      swap_idx;
        dim_t                      dec_idx;
        logic [MAX_DIMS-1:0]       active;
        size_t [MAX_DIMS-1:0]      size;
        count_t                    order_count;
        dim_t [MAX_DIMS-1:0]       order;
    } s2_t;

    typedef struct packed {
        status_t                   status;
        size_t [MAX_DIMS-1:0]      size;
        count_t                    order_count;
        dim_t [MAX_DIMS-1:0]       order;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/tose_check.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tose_check (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            valid_in,
    input  tose_pkg::item_t item,
    input  tose_pkg::cfg_t  cfg,
    output logic            valid_out,
    output tose_pkg::s1_t   s1_out
);
    import tose_pkg::*;

    logic                valid_reg;
    s1_t                 s1_reg;
    s1_t                 s1_next;
    logic [MAX_DIMS-1:0] in_use;

    always_comb
    begin
        s1_next.pre_ok = (item.node == cfg.node_id) &&
                         (item.size_count == cfg.dim_count) &&
                         (cfg.dim_count <= COUNT_W'(MAX_DIMS));
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            in_use[d] = COUNT_W'(d) < cfg.dim_count;
            if (in_use[d] && ((item.size[d] == '0) || (item.size[d] > cfg.extent[d])))
            begin
                s1_next.pre_ok = 1'b0;
            end
            s1_next.active[d] = in_use[d] && (item.size[d] < cfg.extent[d]);
        end
        s1_next.size        = item.size;
        s1_next.order_count = item.order_count;
        s1_next.order       = item.order;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_in)
        begin
            s1_reg <= s1_next;
        end
    end

    assign valid_out = valid_reg;
    assign s1_out    = s1_reg;

endmodule

`default_nettype wire

// ===== hdl/tose_plan.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tose_plan (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           valid_in,
    input  tose_pkg::s1_t  s1_in,
    input  tose_pkg::cfg_t cfg,
    output logic           valid_out,
    output tose_pkg::s2_t  s2_out
);
    import tose_pkg::*;

    logic   valid_reg;
    s2_t    s2_reg;
    s2_t    s2_next;
    count_t acount;
    dim_t   pivot_val;

    always_comb
    begin
        acount = COUNT_W'($countones(s1_in.active));

        // The order must list each active dimension exactly once.
        s2_next.ok = s1_in.pre_ok && (acount == s1_in.order_count);
        for (int k = 0; k < MAX_DIMS; k++)
        begin
            if (COUNT_W'(k) < s1_in.order_count)
            begin
                if (!s1_in.active[s1_in.order[k]])
                begin
                    s2_next.ok = 1'b0;
                end
                for (int j = k + 1; j < MAX_DIMS; j++)
                begin
                    if ((COUNT_W'(j) < s1_in.order_count) &&
                        (s1_in.order[j] == s1_in.order[k]))
                    begin
                        s2_next.ok = 1'b0;
                    end
                end
            end
        end

        // Pivot is the last position that ends an ascending pair.
        s2_next.perm  = 1'b0;
        s2_next.pivot = '0;
        for (int i = 1; i < MAX_DIMS; i++)
        begin
            if ((COUNT_W'(i) < s1_in.order_count) && (s1_in.order[i-1] < s1_in.order[i]))
            begin
                s2_next.perm  = 1'b1;
                s2_next.pivot = DIM_W'(i);
            end
        end

        pivot_val        = s1_in.order[DIM_W'(s2_next.pivot - DIM_W'(1))];
        s2_next.swap_idx = s2_next.pivot;
        for (int j = 1; j < MAX_DIMS; j++)
        begin
            if ((DIM_W'(j) >= s2_next.pivot) && (COUNT_W'(j) < s1_in.order_count) &&
                (s1_in.order[j] > pivot_val))
            begin
                s2_next.swap_idx = DIM_W'(j);
            end
        end

        // Last dimension whose size can still be decremented.
        s2_next.found   = 1'b0;
        s2_next.dec_idx = '0;
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            if ((COUNT_W'(d) < cfg.dim_count) && (s1_in.size[d] > SIZE_W'(1)))
            begin
                s2_next.found   = 1'b1;
                s2_next.dec_idx = DIM_W'(d);
            end
        end

        s2_next.active      = s1_in.active;
        s2_next.size        = s1_in.size;
        s2_next.order_count = s1_in.order_count;
        s2_next.order       = s1_in.order;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_in)
        begin
            s2_reg <= s2_next;
        end
    end

    assign valid_out = valid_reg;
    assign s2_out    = s2_reg;

endmodule

`default_nettype wire

// ===== hdl/tose_build.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tose_build (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid_in,
    input  tose_pkg::s2_t     s2_in,
    input  tose_pkg::cfg_t    cfg,
    output logic              valid_out,
    output tose_pkg::result_t res_out
);
    import tose_pkg::*;

    logic                valid_reg;
    result_t             res_reg;
    result_t             res_next;
    count_t              base;
    count_t              cnt;
    dim_t                pivot_m1;
    logic [MAX_DIMS-1:0] new_active;

    always_comb
    begin
        res_next = '0;
        base     = '0;
        cnt      = '0;
        pivot_m1 = DIM_W'(s2_in.pivot - DIM_W'(1));
        new_active = '0;

        if (!s2_in.ok)
        begin
            res_next.status = ST_NOT_IN_DOMAIN;
        end
        else if (s2_in.perm)
        begin
            res_next.status      = ST_OK;
            res_next.order_count = s2_in.order_count;
            for (int d = 0; d < MAX_DIMS; d++)
            begin
                if (COUNT_W'(d) < cfg.dim_count)
                begin
                    res_next.size[d] = s2_in.size[d];
                end
            end
            // Swap the entry before the pivot with the swap point, then reverse the tail from the pivot on.
            for (int k = 0; k < MAX_DIMS; k++)
            begin
                if (COUNT_W'(k) < s2_in.order_count)
                begin
                    if (DIM_W'(k) < s2_in.pivot)
                    begin
                        base = COUNT_W'(k);
                    end
                    else
                    begin
                        base = COUNT_W'(COUNT_W'(s2_in.pivot) + s2_in.order_count
                                        - COUNT_W'(1) - COUNT_W'(k));
                    end
                    if (base[DIM_W-1:0] == pivot_m1)
                    begin
                        res_next.order[k] = s2_in.order[s2_in.swap_idx];
                    end
                    else if (base[DIM_W-1:0] == s2_in.swap_idx)
                    begin
                        res_next.order[k] = s2_in.order[pivot_m1];
                    end
                    else
                    begin
                        res_next.order[k] = s2_in.order[base[DIM_W-1:0]];
                    end
                end
            end
        end
        else if (s2_in.found)
        begin
            res_next.status = ST_OK;
            // Later dimensions go back to full extent and so become inactive.
            for (int d = 0; d < MAX_DIMS; d++)
            begin
                if (DIM_W'(d) < s2_in.dec_idx)
                begin
                    res_next.size[d] = s2_in.size[d];
                    new_active[d]    = s2_in.active[d];
                end
                else if (DIM_W'(d) == s2_in.dec_idx)
                begin
                    res_next.size[d] = SIZE_W'(s2_in.size[d] - SIZE_W'(1));
                    new_active[d]    = 1'b1;
                end
                else if (COUNT_W'(d) < cfg.dim_count)
                begin
                    res_next.size[d] = cfg.extent[d];
                end
            end
            for (int d = 0; d < MAX_DIMS; d++)
            begin
                if (new_active[d])
                begin
                    res_next.order[cnt[DIM_W-1:0]] = DIM_W'(d);
                    cnt = COUNT_W'(cnt + COUNT_W'(1));
                end
            end
            res_next.order_count = cnt;
        end
        else
        begin
            res_next.status = ST_EXHAUSTED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_in)
        begin
            res_reg <= res_next;
        end
    end

    assign valid_out = valid_reg;
    assign res_out   = res_reg;

endmodule

`default_nettype wire

// ===== hdl/tile_order_space_enumerator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Steps one tiling assignment (tile sizes and loop order) to its successor in
// the search space, or reports it exhausted or not in the domain. A new item
// can be started in every cycle while busy is low. Its result appears on the
// output ports for one cycle with done high, once the item has passed the
// three register stages of the check, plan and build logic. Results cannot
// be held off, so the block never stalls: busy is high only during reset and
// until the first clock edge after it. Configuration writes take effect at
// the next edge and must be made only while no item is in flight.
module tile_order_space_enumerator (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [tose_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [tose_pkg::CFG_DATA_W-1:0] wr_data,
    input  logic                            start,
    output logic                            busy,
    input  logic [tose_pkg::NODE_W-1:0]     in_node,
    input  logic [tose_pkg::COUNT_W-1:0]    size_count,
    input  logic [tose_pkg::SIZE_W-1:0]     tile_size_0,
    input  logic [tose_pkg::SIZE_W-1:0]     tile_size_1,
    input  logic [tose_pkg::SIZE_W-1:0]     tile_size_2,
    input  logic [tose_pkg::SIZE_W-1:0]     tile_size_3,
    input  logic [tose_pkg::COUNT_W-1:0]    order_count,
    input  logic [tose_pkg::DIM_W-1:0]      order_0,
    input  logic [tose_pkg::DIM_W-1:0]      order_1,
    input  logic [tose_pkg::DIM_W-1:0]      order_2,
    input  logic [tose_pkg::DIM_W-1:0]      order_3,
    output logic                            done,
    output logic [tose_pkg::STATUS_W-1:0]   status,
    output logic [tose_pkg::SIZE_W-1:0]     next_size_0,
    output logic [tose_pkg::SIZE_W-1:0]     next_size_1,
    output logic [tose_pkg::SIZE_W-1:0]     next_size_2,
    output logic [tose_pkg::SIZE_W-1:0]     next_size_3,
    output logic [tose_pkg::COUNT_W-1:0]    next_order_count,
    output logic [tose_pkg::DIM_W-1:0]      next_order_0,
    output logic [tose_pkg::DIM_W-1:0]      next_order_1,
    output logic [tose_pkg::DIM_W-1:0]      next_order_2,
    output logic [tose_pkg::DIM_W-1:0]      next_order_3
);
    import tose_pkg::*;

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    logic    busy_reg;
    item_t   item;
    logic    accept;
    logic    v1;
    logic    v2;
    logic    v3;
    s1_t     s1;
    s2_t     s2;
    result_t res;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            if (wr_index == REG_NODE_ID)
            begin
                cfg_next.node_id = wr_data[NODE_W-1:0];
            end
            else if (wr_index == REG_DIM_COUNT)
            begin
                cfg_next.dim_count = wr_data[COUNT_W-1:0];
            end
            else
            begin
                for (int d = 0; d < MAX_DIMS; d++)
                begin
                    if (wr_index == CFG_IDX_W'(REG_EXTENT_0 + CFG_IDX_W'(d)))
                    begin
                        cfg_next.extent[d] = wr_data[SIZE_W-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.node_id   <= '0;
            cfg_reg.dim_count <= COUNT_W'(MAX_DIMS);
            for (int d = 0; d < MAX_DIMS; d++)
            begin
                cfg_reg.extent[d] <= SIZE_W'(1);
            end
            busy_reg <= 1'b1;
        end
        else
        begin
            cfg_reg  <= cfg_next;
            busy_reg <= 1'b0;
        end
    end

    assign busy   = busy_reg;
    assign accept = start && !busy_reg;

    always_comb
    begin
        item.node        = in_node;
        item.size_count  = size_count;
        item.size[0]     = tile_size_0;
        item.size[1]     = tile_size_1;
        item.size[2]     = tile_size_2;
        item.size[3]     = tile_size_3;
        item.order_count = order_count;
        item.order[0]    = order_0;
        item.order[1]    = order_1;
        item.order[2]    = order_2;
        item.order[3]    = order_3;
    end

    tose_check u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (accept),
        .item      (item),
        .cfg       (cfg_reg),
        .valid_out (v1),
        .s1_out    (s1)
    );

    tose_plan u_plan (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (v1),
        .s1_in     (s1),
        .cfg       (cfg_reg),
        .valid_out (v2),
        .s2_out    (s2)
    );

    tose_build u_build (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (v2),
        .s2_in     (s2),
        .cfg       (cfg_reg),
        .valid_out (v3),
        .res_out   (res)
    );

    assign done             = v3;
    assign status           = res.status;
    assign next_size_0      = res.size[0];
    assign next_size_1      = res.size[1];
    assign next_size_2      = res.size[2];
    assign next_size_3      = res.size[3];
    assign next_order_count = res.order_count;
    assign next_order_0     = res.order[0];
    assign next_order_1     = res.order[1];
    assign next_order_2     = res.order[2];
    assign next_order_3     = res.order[3];

endmodule

`default_nettype wire

// ===== hdl/tose_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "tile_order_space_enumerator_assert.svh"

module tose_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            wr_en,
    input logic [tose_pkg::CFG_IDX_W-1:0]  wr_index,
    input logic [tose_pkg::CFG_DATA_W-1:0] wr_data,
    input logic                            start,
    input logic                            busy,
    input logic [tose_pkg::NODE_W-1:0]     in_node,
    input logic [tose_pkg::COUNT_W-1:0]    size_count,
    input logic [tose_pkg::SIZE_W-1:0]     tile_size_0,
    input logic [tose_pkg::SIZE_W-1:0]     tile_size_1,
    input logic [tose_pkg::SIZE_W-1:0]     tile_size_2,
    input logic [tose_pkg::SIZE_W-1:0]     tile_size_3,
    input logic [tose_pkg::COUNT_W-1:0]    order_count,
    input logic [tose_pkg::DIM_W-1:0]      order_0,
    input logic [tose_pkg::DIM_W-1:0]      order_1,
    input logic [tose_pkg::DIM_W-1:0]      order_2,
    input logic [tose_pkg::DIM_W-1:0]      order_3,
    input logic                            done,
    input logic [tose_pkg::STATUS_W-1:0]   status,
    input logic [tose_pkg::SIZE_W-1:0]     next_size_0,
    input logic [tose_pkg::SIZE_W-1:0]     next_size_1,
    input logic [tose_pkg::SIZE_W-1:0]     next_size_2,
    input logic [tose_pkg::SIZE_W-1:0]     next_size_3,
    input logic [tose_pkg::COUNT_W-1:0]    next_order_count,
    input logic [tose_pkg::DIM_W-1:0]      next_order_0,
    input logic [tose_pkg::DIM_W-1:0]      next_order_1,
    input logic [tose_pkg::DIM_W-1:0]      next_order_2,
    input logic [tose_pkg::DIM_W-1:0]      next_order_3
);
    import tose_pkg::*;

    logic fields_zero;

    assign fields_zero = (next_size_0 == '0) && (next_size_1 == '0) &&
                         (next_size_2 == '0) && (next_size_3 == '0) &&
                         (next_order_count == '0) && (next_order_0 == '0) &&
                         (next_order_1 == '0) && (next_order_2 == '0) &&
                         (next_order_3 == '0);

    // Every accepted item yields a result, and every result comes from an accepted item.
    `TOSE_ASSERT(a_latency, (start && !busy) |-> ##3 done, "result missing after item")
    `TOSE_ASSERT(a_no_extra, done |-> $past(start && !busy, 3), "result without item")
    `TOSE_ASSERT(a_fail_zero, (done && (status != ST_OK)) |-> fields_zero,
                 "fields not cleared on failure")
    `TOSE_ASSERT(a_order_len, (done && (status == ST_OK)) |->
                 (next_order_count <= COUNT_W'(MAX_DIMS)), "order count too large")
    `TOSE_ASSERT_RST(a_reset_quiet, !rst_n |-> (busy && !done), "activity during reset")

endmodule

bind tile_order_space_enumerator tose_checker u_tose_checker (.*);

`default_nettype wire
